// ===== rtl/core/huffman_table_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// huffman table encoder assertion macros
// shared concurrent assertion forms, clocked on aclk and off during reset
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_ENCODER_DEFINES_SVH
`define HUFFMAN_TABLE_ENCODER_DEFINES_SVH

// condition holds at every edge out of reset
`define HTE_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define HTE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define HTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hte_pkg.sv =====
// ----------------------------------------------------------------------------
// hte_pkg
// types, constants and field offsets shared by the huffman table encoder
// ----------------------------------------------------------------------------
`default_nettype none

package hte_pkg;

    // code table geometry
    localparam int MAX_CODE_BITS = 32;
    localparam int SYMBOLS       = 256;
    localparam int ADDR_W        = $clog2(SYMBOLS);
    localparam int LEN_W         = 6;
    localparam int ENTRY_W       = MAX_CODE_BITS + LEN_W;

    // frame header limits
    localparam int FLEN_W    = 15;
    localparam int HALF_CHAR = 127;
    localparam int LIMIT_LEN = HALF_CHAR * 255;

    // packer window: pending bits plus one longest code, in whole bytes
    localparam int BURST_BYTES = (MAX_CODE_BITS + 7 + 7) / 8;
    localparam int BURST_W     = BURST_BYTES * 8;
    localparam int CNT_W       = $clog2(BURST_BYTES + 1);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

    // input word layout, lowest field first
    localparam int IN_USER_W   = 2;
    localparam int IDX_LSB     = 0;
    localparam int CODE_LSB    = IDX_LSB + 8;
    localparam int CLEN_LSB    = CODE_LSB + 32;
    localparam int FLEN_LSB    = CLEN_LSB + LEN_W;
    localparam int DBYTE_LSB   = FLEN_LSB + FLEN_W;
    localparam int IN_FIELDS_W = DBYTE_LSB + 8;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // output word layout
    localparam int OUT_TDATA_W  = 8;
    localparam int OUT_USER_W   = 2;
    localparam int USER_HDR_BIT = 0;
    localparam int USER_ERR_BIT = 1;

    typedef enum logic [IN_USER_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_BYTE  = 2'd2
    } opcode_t;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_BYTE  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [FLEN_W-1:0]        frame_length;
        logic [MAX_CODE_BITS-1:0] code;
        logic [LEN_W-1:0]         len;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_beat_t;

endpackage

`default_nettype wire

// ===== rtl/core/hte_ram.sv =====
// ----------------------------------------------------------------------------
// hte_ram
// generic single write port memory with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module hte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hte_front.sv =====
// ----------------------------------------------------------------------------
// hte_front
// accepts input words, writes table entries and turns start and byte words
// into packer commands with the looked up code
// ----------------------------------------------------------------------------
`default_nettype none

module hte_front
    import hte_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    output cmd_beat_t             push,
    input  logic                  push_ready
);

    logic [ADDR_W-1:0]        entry_index;
    logic [MAX_CODE_BITS-1:0] code_word;
    logic [LEN_W-1:0]         code_length;
    logic [LEN_W-1:0]         len_sat;
    logic [FLEN_W-1:0]        frame_length;
    logic [ADDR_W-1:0]        data_byte;
    logic                     accept;
    logic                     table_we;
    logic                     table_re;
    logic [ENTRY_W-1:0]       table_rdata;

    logic                     st1_valid_reg, st1_valid_next;
    cmd_kind_t                st1_kind_reg, st1_kind_next;
    logic [FLEN_W-1:0]        st1_flen_reg, st1_flen_next;

    assign entry_index  = s_tdata[IDX_LSB +: ADDR_W];
    assign code_word    = s_tdata[CODE_LSB +: MAX_CODE_BITS];
    assign code_length  = s_tdata[CLEN_LSB +: LEN_W];
    assign frame_length = s_tdata[FLEN_LSB +: FLEN_W];
    assign data_byte    = s_tdata[DBYTE_LSB +: ADDR_W];

    assign len_sat = (code_length > LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
                                                          : code_length;

    // stage one moves on when it is empty or the queue takes it
    assign s_tready = !st1_valid_reg || push_ready;
    assign accept   = s_tvalid && s_tready;
    assign table_we = accept && (s_tuser == OP_LOAD);
    assign table_re = accept && (s_tuser == OP_BYTE);

    hte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOLS)
    ) u_table (
        .aclk  (aclk),
        .we    (table_we),
        .waddr (entry_index),
        .wdata ({len_sat, code_word}),
        .re    (table_re),
        .raddr (data_byte),
        .rdata (table_rdata)
    );

    always_comb begin
        st1_valid_next = st1_valid_reg && !push_ready;
        st1_kind_next  = st1_kind_reg;
        st1_flen_next  = st1_flen_reg;
        if (accept) begin
            case (s_tuser)
                OP_START: begin
                    st1_valid_next = 1'b1;
                    st1_kind_next  = CMD_START;
                    st1_flen_next  = frame_length;
                end
                OP_BYTE: begin
                    st1_valid_next = 1'b1;
                    st1_kind_next  = CMD_BYTE;
                end
                default: begin
                    // loads go straight to the table, unused codes are dropped
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
        end
        st1_kind_reg <= st1_kind_next;
        st1_flen_reg <= st1_flen_next;
    end

    assign push.valid            = st1_valid_reg;
    assign push.cmd.kind         = st1_kind_reg;
    assign push.cmd.frame_length = st1_flen_reg;
    assign push.cmd.code         = table_rdata[MAX_CODE_BITS-1:0];
    assign push.cmd.len          = table_rdata[ENTRY_W-1 -: LEN_W];

endmodule

`default_nettype wire

// ===== rtl/core/hte_queue.sv =====
// ----------------------------------------------------------------------------
// hte_queue
// short command queue that decouples the front from the packer
// ----------------------------------------------------------------------------
`default_nettype none

module hte_queue
    import hte_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_beat_t push,
    output logic      push_ready,
    output cmd_beat_t head,
    input  logic      pop
);

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != (Q_PTR_W+1)'(QUEUE_DEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hte_back.sv =====
// ----------------------------------------------------------------------------
// hte_back
// frame state, barrel bit packer and byte sequencer in front of the output
// register
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_table_encoder_defines.svh"

module hte_back
    import hte_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_beat_t              head,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic [OUT_USER_W-1:0]  m_tuser
);

    // frame state
    logic [7:0]              partial_reg, partial_next;
    logic [2:0]              bitpos_reg, bitpos_next;
    logic [FLEN_W-1:0]       remaining_reg, remaining_next;
    logic                    in_frame_reg, in_frame_next;

    // burst of bytes waiting for the output register
    logic [BURST_W-1:0]      burst_word_reg, burst_word_next;
    logic [CNT_W-1:0]        burst_cnt_reg, burst_cnt_next;
    logic                    burst_last_reg, burst_last_next;
    logic [OUT_USER_W-1:0]   burst_user_reg, burst_user_next;

    // output register
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                    m_tlast_reg, m_tlast_next;
    logic [OUT_USER_W-1:0]   m_tuser_reg, m_tuser_next;

    logic                    out_load;
    logic                    emit;
    logic                    burst_free;

    // packer datapath
    logic [LEN_W-1:0]         len_eff;
    logic [LEN_W-1:0]         total_bits;
    logic [LEN_W-1:0]         shift_amt;
    logic [MAX_CODE_BITS-1:0] code_masked;
    logic [BURST_W-1:0]       window;
    logic [BURST_W-1:0]       window_at_full;
    logic [CNT_W-1:0]         full_bytes;
    logic [2:0]               rem_bits;
    logic [FLEN_W-1:0]        remaining_dec;
    logic                     final_byte;

    // header datapath
    logic [FLEN_W-1:0]        flen;
    logic [7:0]               hdr_high;

    assign len_eff     = (head.cmd.len > LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
                                                               : head.cmd.len;
    assign total_bits  = LEN_W'(bitpos_reg) + len_eff;
    assign shift_amt   = LEN_W'(BURST_W) - total_bits;
    assign code_masked = head.cmd.code & ~({MAX_CODE_BITS{1'b1}} << len_eff);
    assign window      = {partial_reg, {(BURST_W-8){1'b0}}}
                       | (BURST_W'(code_masked) << shift_amt);
    assign full_bytes  = CNT_W'(total_bits >> 3);
    assign rem_bits    = total_bits[2:0];
    assign window_at_full = window << {full_bytes, 3'b000};

    assign remaining_dec = remaining_reg - 1'b1;
    assign final_byte    = (remaining_dec == '0);

    assign flen     = head.cmd.frame_length;
    assign hdr_high = 8'(HALF_CHAR + 1) + 8'(flen >> 8);

    // output register loads when empty or drained this cycle
    assign out_load   = !m_tvalid_reg || m_tready;
    assign emit       = (burst_cnt_reg != '0) && out_load;
    assign burst_free = (burst_cnt_reg == '0) || ((burst_cnt_reg == CNT_W'(1)) && out_load);
    assign pop        = head.valid && burst_free;

    always_comb begin
        partial_next    = partial_reg;
        bitpos_next     = bitpos_reg;
        remaining_next  = remaining_reg;
        in_frame_next   = in_frame_reg;
        burst_word_next = burst_word_reg;
        burst_cnt_next  = burst_cnt_reg;
        burst_last_next = burst_last_reg;
        burst_user_next = burst_user_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        m_tuser_next    = m_tuser_reg;

        if (emit) begin
            m_tvalid_next   = 1'b1;
            m_tdata_next    = burst_word_reg[BURST_W-1 -: 8];
            m_tlast_next    = burst_last_reg && (burst_cnt_reg == CNT_W'(1));
            m_tuser_next    = burst_user_reg;
            burst_word_next = burst_word_reg << 8;
            burst_cnt_next  = burst_cnt_reg - 1'b1;
        end

        if (pop) begin
            case (head.cmd.kind)
                CMD_START: begin
                    // any open frame is dropped
                    partial_next   = '0;
                    bitpos_next    = '0;
                    remaining_next = '0;
                    in_frame_next  = 1'b0;
                    burst_user_next = '0;
                    if (flen >= FLEN_W'(LIMIT_LEN)) begin
                        burst_word_next = '0;
                        burst_cnt_next  = CNT_W'(1);
                        burst_last_next = 1'b0;
                        burst_user_next[USER_ERR_BIT] = 1'b1;
                    end else begin
                        burst_user_next[USER_HDR_BIT] = 1'b1;
                        if (flen >= FLEN_W'(HALF_CHAR)) begin
                            burst_word_next = {hdr_high, flen[7:0], {(BURST_W-16){1'b0}}};
                            burst_cnt_next  = CNT_W'(2);
                            burst_last_next = 1'b0;
                        end else begin
                            burst_word_next = {flen[7:0], {(BURST_W-8){1'b0}}};
                            burst_cnt_next  = CNT_W'(1);
                            burst_last_next = (flen == '0);
                        end
                        if (flen != '0) begin
                            remaining_next = flen;
                            in_frame_next  = 1'b1;
                        end
                    end
                end
                CMD_BYTE: begin
                    if (in_frame_reg) begin
                        burst_word_next = window;
                        burst_user_next = '0;
                        remaining_next  = remaining_dec;
                        if (final_byte) begin
                            // pad the partial byte and close the frame
                            burst_cnt_next  = full_bytes + CNT_W'(rem_bits != 3'd0);
                            burst_last_next = 1'b1;
                            partial_next    = '0;
                            bitpos_next     = '0;
                            in_frame_next   = 1'b0;
                        end else begin
                            burst_cnt_next  = full_bytes;
                            burst_last_next = 1'b0;
                            partial_next    = window_at_full[BURST_W-1 -: 8];
                            bitpos_next     = rem_bits;
                        end
                    end else begin
                        burst_cnt_next = '0;
                    end
                end
                default: begin
                    burst_cnt_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg   <= '0;
            bitpos_reg    <= '0;
            remaining_reg <= '0;
            in_frame_reg  <= 1'b0;
            burst_cnt_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            partial_reg   <= partial_next;
            bitpos_reg    <= bitpos_next;
            remaining_reg <= remaining_next;
            in_frame_reg  <= in_frame_next;
            burst_cnt_reg <= burst_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        burst_word_reg <= burst_word_next;
        burst_last_reg <= burst_last_next;
        burst_user_reg <= burst_user_next;
        m_tdata_reg    <= m_tdata_next;
        m_tlast_reg    <= m_tlast_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `HTE_ASSERT_HOLDS(a_burst_fits, burst_cnt_reg <= CNT_W'(BURST_BYTES), "burst count overflow")
    `HTE_ASSERT_IMPLIES(a_open_has_bytes, in_frame_reg, remaining_reg != '0, "open frame empty")
    `HTE_ASSERT_IMPLIES(a_closed_clean, !in_frame_reg, (bitpos_reg == '0) && (partial_reg == '0), "bits pending outside frame")
    `HTE_ASSERT_NEXT(a_start_clears, pop && (head.cmd.kind == CMD_START), (bitpos_reg == '0) && (partial_reg == '0), "start left bits pending")

endmodule

`default_nettype wire

// ===== rtl/core/huffman_table_encoder.sv =====
// ----------------------------------------------------------------------------
// huffman_table_encoder
// static huffman encoder for byte symbols with a loadable 256 entry code table
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                    | tuser        | tlast
//  --------+-----+------------------------------------------+--------------+------
//  s_      | in  | entry_index, code_word, code_length,     | opcode       | -
//          |     | frame_length, data_byte (72 bits)        |              |
//  m_      | out | out_byte                                 | is_header,   | last
//          |     |                                          | too_long     |
//
//  an input word is taken every cycle while the command queue has room
//  each start or byte word makes up to five output words; the packer takes
//  the next command as the last of them loads the output register, so one word
//  per cycle when each gives at most one and m_ does not stall
//  a word passes stage one and the table read, the queue, the burst register
//  and the output register; aresetn clears frame state, queue and output
//  register; the code table is not cleared, the user must read entries only
//  after a load and the block does not enforce it; backpressure on m_ stalls
//  the packer, then fills the four entry queue, then drops s_tready
`default_nettype none

module huffman_table_encoder
    import hte_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // input channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // entry_index[7:0], code_word[39:8], code_length[45:40],
    // frame_length[60:46], data_byte[68:61], zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  logic [IN_USER_W-1:0]   s_tuser,
    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_byte[7:0]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    // is_header[0], too_long[1]
    output logic [OUT_USER_W-1:0]  m_tuser
);

    // front to queue
    cmd_beat_t push;
    logic      push_ready;

    // queue to packer
    cmd_beat_t head;
    logic      pop;

    // classify words, own the code table, look up codes
    hte_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_ready (push_ready)
    );

    // lets the front keep taking words while the packer drains a burst
    hte_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    // frame state, bit packer and output register
    hte_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== verif/huffman_table_encoder_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_table_encoder_checker
// watches both channels of the encoder, predicts each output word from the
// accepted input words and compares them in order, field by field
// ----------------------------------------------------------------------------

module huffman_table_encoder_checker
    import hte_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tlast,
    input  logic [OUT_USER_W-1:0]  m_tuser,
    output int                     mismatch_count,
    output int                     pending_count,
    output int                     checked_count
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       last;
        logic       too_long;
    } enc_word_t;

    enc_word_t expected_words[$];

    // code table, kept with lengths already saturated
    logic [MAX_CODE_BITS-1:0] code_bits [SYMBOLS];
    logic [LEN_W-1:0]         code_len  [SYMBOLS];

    // bit packer and frame state
    logic [7:0]        partial_byte;
    logic [2:0]        bit_pos;
    logic [FLEN_W-1:0] bytes_left;
    logic              in_frame;

    function automatic enc_word_t mk_word(logic [7:0] b, logic hdr, logic lst, logic err);
        enc_word_t w;
        w.out_byte  = b;
        w.is_header = hdr;
        w.last      = lst;
        w.too_long  = err;
        return w;
    endfunction

    function automatic string show(enc_word_t w);
        return $sformatf("byte %02h hdr %0b last %0b too_long %0b",
                         w.out_byte, w.is_header, w.last, w.too_long);
    endfunction

    task automatic encode_symbol(input logic [7:0] sym);
        enc_word_t   burst [6];
        int          k;
        int unsigned n;
        int unsigned clen;
        logic [63:0] acc;
        logic        last_symbol;
        k = 0;
        if (in_frame) begin
            clen = code_len[sym];
            n    = bit_pos;
            // pending bits right aligned, then the new code appended below them
            acc  = {56'd0, partial_byte} >> (8 - n);
            acc  = (acc << clen) | ({32'd0, code_bits[sym]} & ((64'd1 << clen) - 64'd1));
            n    = n + clen;
            bytes_left  = bytes_left - 1'b1;
            last_symbol = (bytes_left == '0);
            while (n >= 8) begin
                n = n - 8;
                burst[k] = mk_word(8'(acc >> n), 1'b0, 1'b0, 1'b0);
                k++;
            end
            acc          = acc & ((64'd1 << n) - 64'd1);
            partial_byte = 8'(acc << (8 - n));
            bit_pos      = 3'(n);
            if (last_symbol) begin
                // flush a zero padded partial byte, else tag the last full one
                if (n > 0) begin
                    burst[k] = mk_word(partial_byte, 1'b0, 1'b1, 1'b0);
                    k++;
                end else if (k > 0) begin
                    burst[k-1].last = 1'b1;
                end
                partial_byte = '0;
                bit_pos      = '0;
                in_frame     = 1'b0;
            end
            for (int i = 0; i < k; i++)
                expected_words.push_back(burst[i]);
        end
    endtask

    task automatic predict_word(input logic [IN_USER_W-1:0] op,
                                input logic [IN_TDATA_W-1:0] data);
        logic [7:0]        idx;
        logic [LEN_W-1:0]  clen;
        logic [FLEN_W-1:0] flen;
        case (op)
            OP_LOAD: begin
                idx  = data[IDX_LSB +: 8];
                clen = data[CLEN_LSB +: LEN_W];
                if (clen > MAX_CODE_BITS)
                    clen = LEN_W'(MAX_CODE_BITS);
                code_bits[idx] = data[CODE_LSB +: MAX_CODE_BITS];
                code_len[idx]  = clen;
            end
            OP_START: begin
                flen         = data[FLEN_LSB +: FLEN_W];
                partial_byte = '0;
                bit_pos      = '0;
                bytes_left   = '0;
                in_frame     = 1'b0;
                if (flen >= LIMIT_LEN) begin
                    expected_words.push_back(mk_word(8'd0, 1'b0, 1'b0, 1'b1));
                end else begin
                    if (flen >= HALF_CHAR) begin
                        expected_words.push_back(
                            mk_word(8'(HALF_CHAR + 1 + flen / 256), 1'b1, 1'b0, 1'b0));
                        expected_words.push_back(mk_word(flen[7:0], 1'b1, 1'b0, 1'b0));
                    end else begin
                        expected_words.push_back(
                            mk_word(flen[7:0], 1'b1, flen == '0, 1'b0));
                    end
                    if (flen != '0) begin
                        bytes_left = flen;
                        in_frame   = 1'b1;
                    end
                end
            end
            OP_BYTE: encode_symbol(data[DBYTE_LSB +: 8]);
            default: ;
        endcase
    endtask

    task automatic check_word(input enc_word_t got);
        enc_word_t want;
        checked_count++;
        if (expected_words.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected output word, expected nothing, got %s", $time, show(got));
        end else begin
            want = expected_words.pop_front();
            if (got.out_byte !== want.out_byte || got.is_header !== want.is_header ||
                got.last !== want.last || got.too_long !== want.too_long) begin
                mismatch_count++;
                $display("%0t: output word mismatch, expected %s, got %s",
                         $time, show(want), show(got));
            end
        end
    endtask

    // input side first, so a word and its own results never race within an edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_words.delete();
            partial_byte   = '0;
            bit_pos        = '0;
            bytes_left     = '0;
            in_frame       = 1'b0;
            mismatch_count = 0;
            checked_count  = 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_word(mk_word(m_tdata, m_tuser[USER_HDR_BIT], m_tlast,
                                   m_tuser[USER_ERR_BIT]));
        end
        pending_count = expected_words.size();
    end

endmodule

// ===== verif/tb_huffman_table_encoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_huffman_table_encoder
// drives table loads, frame starts and data bytes into the encoder with
// random idling on both channels; the checker beside the block predicts
// and compares every output word
// ----------------------------------------------------------------------------

module tb_huffman_table_encoder;
    import hte_pkg::*;

    // opcode the block has no use for, it must be swallowed without output
    localparam logic [IN_USER_W-1:0] OP_SPARE = 2'd3;

    localparam int RANDOM_WORDS = 130;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE       = 16;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // entry_index, code_word, code_length, frame_length, data_byte, zero fill
    logic [IN_TDATA_W-1:0]  s_tdata;
    // opcode
    logic [IN_USER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // out_byte
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    // is_header, too_long
    logic [OUT_USER_W-1:0]  m_tuser;

    int mismatches;
    int pending;
    int checked;

    // calm: both sides stop idling; hold_req: receiver stalls for a long stretch
    bit calm;
    bit hold_req;

    int words_sent;
    int frames_started;
    int loads_done;

    logic [7:0] loaded_syms[$];
    bit         is_loaded [SYMBOLS];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    huffman_table_encoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    huffman_table_encoder_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatches),
        .pending_count  (pending),
        .checked_count  (checked)
    );

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // every field random, so fields an opcode does not use still toggle
    function automatic logic [IN_TDATA_W-1:0] noise_word();
        logic [95:0]           r;
        logic [IN_TDATA_W-1:0] w;
        r = {$urandom, $urandom, $urandom};
        w = '0;
        w[IN_FIELDS_W-1:0] = r[IN_FIELDS_W-1:0];
        return w;
    endfunction

    function automatic logic [7:0] pick_symbol();
        return loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
    endfunction

    // idle for a drawn gap, then offer the word until it is taken
    task automatic send_word(input logic [IN_USER_W-1:0] op,
                             input logic [IN_TDATA_W-1:0] data);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic load_entry(input logic [7:0] idx, input logic [31:0] code,
                              input logic [LEN_W-1:0] clen);
        logic [IN_TDATA_W-1:0] w;
        w = noise_word();
        w[IDX_LSB +: 8]              = idx;
        w[CODE_LSB +: MAX_CODE_BITS] = code;
        w[CLEN_LSB +: LEN_W]         = clen;
        if (!is_loaded[idx]) begin
            is_loaded[idx] = 1'b1;
            loaded_syms.push_back(idx);
        end
        loads_done++;
        send_word(OP_LOAD, w);
    endtask

    task automatic random_load();
        logic [LEN_W-1:0] clen;
        // mostly legal lengths, now and then zero or past the saturation point
        if ($urandom_range(0, 9) == 0)
            clen = LEN_W'($urandom_range(0, 63));
        else
            clen = LEN_W'($urandom_range(1, MAX_CODE_BITS));
        load_entry(8'($urandom_range(0, 255)), $urandom, clen);
    endtask

    task automatic start_frame(input logic [FLEN_W-1:0] flen);
        logic [IN_TDATA_W-1:0] w;
        w = noise_word();
        w[FLEN_LSB +: FLEN_W] = flen;
        frames_started++;
        send_word(OP_START, w);
    endtask

    task automatic send_symbol(input logic [7:0] sym);
        logic [IN_TDATA_W-1:0] w;
        w = noise_word();
        w[DBYTE_LSB +: 8] = sym;
        send_word(OP_BYTE, w);
    endtask

    // sender pauses until every predicted word has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // receiver: a drawn stall per word, one long hold-off on request
    initial begin
        int gap;
        m_tready <= 1'b0;
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // stimulus and verdict
    initial begin
        int flen;
        int nbytes;
        int counted;
        int roll;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        aresetn  <= 1'b0;
        calm     = 1'b0;
        hold_req = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: code extremes, zero and saturated lengths
        load_entry(8'hFF, 32'hFFFF_FFFF, 6'd32);
        load_entry(8'h02, 32'h0000_0005, 6'd3);
        load_entry(8'h5A, $urandom, 6'd0);
        load_entry(8'hA5, 32'h8000_0001, 6'd63);
        // empty frame, then a data byte with no frame open
        start_frame(15'd0);
        send_symbol(8'h02);
        // oversized, then the largest legal length and restarts around 127
        start_frame(15'(LIMIT_LEN));
        start_frame(15'(LIMIT_LEN - 1));
        start_frame(15'(HALF_CHAR - 1));
        start_frame(15'(HALF_CHAR));
        // five output words from one symbol, table load inside the frame
        start_frame(15'd3);
        send_symbol(8'hFF);
        send_symbol(8'h02);
        load_entry(8'h10, $urandom, 6'd5);
        send_symbol(8'hA5);
        // zero-length codes end the frame with nothing pending: no last at all
        start_frame(15'd2);
        send_symbol(8'h5A);
        send_symbol(8'h5A);
        // zero-length code closes a frame with bits pending
        start_frame(15'd2);
        send_symbol(8'h02);
        send_symbol(8'h5A);
        // byte-aligned end, last rides on the final full byte
        start_frame(15'd1);
        send_symbol(8'hFF);
        send_word(OP_SPARE, noise_word());
        drain();

        // back pressure: long receiver stall while the sender keeps offering
        hold_req = 1'b1;
        calm     = 1'b1;
        start_frame(15'd20);
        repeat (20) send_symbol(8'hFF);
        calm = 1'b0;
        drain();

        // random frames, mostly well formed, some cut short or oversized
        counted = 0;
        repeat (8) begin
            random_load();
            counted++;
        end
        while (counted < RANDOM_WORDS) begin
            calm = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 19);
            if (roll == 0)
                flen = $urandom_range(LIMIT_LEN, 32767);
            else if (roll == 1)
                flen = $urandom_range(0, 32767);
            else if (roll == 2)
                flen = $urandom_range(HALF_CHAR, 300);
            else if (roll == 3)
                flen = 0;
            else
                flen = $urandom_range(1, 10);
            start_frame(15'(flen));
            counted++;
            if (flen >= LIMIT_LEN)
                nbytes = 0;
            else if (flen <= 10)
                nbytes = flen;
            else
                nbytes = $urandom_range(0, 12);
            // now and then a frame is abandoned by the next start
            if (nbytes > 0 && $urandom_range(0, 7) == 0)
                nbytes = $urandom_range(0, nbytes - 1);
            for (int i = 0; i < nbytes; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    random_load();
                    counted++;
                end
                if ($urandom_range(0, 24) == 0)
                    send_word(OP_SPARE, noise_word());
                send_symbol(pick_symbol());
                counted++;
            end
            // stray byte after a closed frame
            if (nbytes == flen && $urandom_range(0, 5) == 0)
                send_symbol(pick_symbol());
            if ($urandom_range(0, 9) == 0)
                drain();
        end
        calm = 1'b0;

        drain();
        repeat (SETTLE) @(posedge aclk);
        $display("run covered %0d input words: %0d frame starts, %0d table loads",
                 words_sent, frames_started, loads_done);
        $display("%0d output words checked, incl. oversized, empty and restarted frames",
                 checked);
        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hte_pkg.sv
rtl/core/hte_ram.sv
rtl/core/hte_front.sv
rtl/core/hte_queue.sv
rtl/core/hte_back.sv
rtl/core/huffman_table_encoder.sv
verif/huffman_table_encoder_checker.sv
verif/tb_huffman_table_encoder.sv
